>>> rtl/core/sdtq_pkg.sv
`timescale 1ns / 1ps
// Package for the sorted deadline timer queue.
// Holds codes, controller states and the command/status structs; depends on nothing.
package sdtq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int TIME_BITS_DEF = 32;
    localparam int HANDLE_BITS   = 4;
    localparam int STATUS_BITS   = 3;
    localparam int IN_TIME_BITS  = 32;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_DELETE = 2'd1;
    localparam logic [1:0] FUNC_ADJUST = 2'd2;
    localparam logic [1:0] FUNC_TICK   = 2'd3;

    localparam logic [STATUS_BITS-1:0] ST_DONE    = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_EXPIRED = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_NONE    = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_FULL    = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_PRESENT = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_MISSING = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REINS
    } state_t;

    typedef struct packed {
        logic load;
        logic ins;
        logic del;
        logic pop;
    } cmd_t;

    typedef struct packed {
        logic                   found;
        logic                   full;
        logic                   head_exp;
        logic                   next_exp;
        logic [HANDLE_BITS-1:0] head_owner;
    } stat_t;

endpackage

>>> rtl/core/sorted_deadline_timer_queue.sv
`timescale 1ns / 1ps
// Top level of the sorted deadline timer queue: joins controller and cell-row datapath.
// Depends on sdtq_pkg, sdtq_ctrl and sdtq_datapath.

// Keeps up to DEPTH timers sorted by expiry in a row of compare-and-shift cells;
// equal expiries stay in arrival order. One operation is in hand at a time: a word is
// taken in S_IDLE and executed in S_EXEC once the output register is free; adjust
// removes the timer in S_EXEC and re-places it in S_REINS, and a tick pops one expired
// timer per step, each popped result leaving in its own output word. The single
// output register sets that pace; when the consumer stalls, execution waits on it.
module sorted_deadline_timer_queue #(
    parameter int DEPTH     = sdtq_pkg::DEPTH_DEF,
    parameter int TIME_BITS = sdtq_pkg::TIME_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // func[1:0], handle[5:2], expire_time[37:6], now[69:38]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_handle[3:0], status[6:4]
    output logic        m_tlast
);

    sdtq_pkg::cmd_t  cmd;
    sdtq_pkg::stat_t stat;
    logic [63:0] exp_ext;
    logic [63:0] now_ext;
    logic [sdtq_pkg::HANDLE_BITS-1:0] handle_q;
    logic [sdtq_pkg::HANDLE_BITS-1:0] out_handle;
    logic [sdtq_pkg::STATUS_BITS-1:0] out_status;

    // Input times are zero-extended and then cut to the stored width.
    assign exp_ext = {32'b0, s_tdata[37:6]};
    assign now_ext = {32'b0, s_tdata[69:38]};

    sdtq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_func    (s_tdata[1:0]),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_handle (out_handle),
        .out_status (out_status),
        .out_last   (m_tlast),
        .handle_q   (handle_q),
        .stat       (stat),
        .cmd        (cmd)
    );

    sdtq_datapath #(
        .DEPTH     (DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_handle (s_tdata[5:2]),
        .in_time   (exp_ext[TIME_BITS-1:0]),
        .in_now    (now_ext[TIME_BITS-1:0]),
        .handle_q  (handle_q),
        .stat      (stat)
    );

    assign m_tdata = {1'b0, out_status, out_handle};

endmodule

>>> rtl/core/sdtq_datapath.sv
`timescale 1ns / 1ps
// Datapath of the timer queue: a row of compare-and-shift cells plus operand registers.
// Depends on sdtq_pkg.
module sdtq_datapath #(
    parameter int DEPTH     = sdtq_pkg::DEPTH_DEF,
    parameter int TIME_BITS = sdtq_pkg::TIME_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sdtq_pkg::cmd_t                   cmd,
    input  logic [sdtq_pkg::HANDLE_BITS-1:0] in_handle,
    input  logic [TIME_BITS-1:0]             in_time,
    input  logic [TIME_BITS-1:0]             in_now,
    output logic [sdtq_pkg::HANDLE_BITS-1:0] handle_q,
    output sdtq_pkg::stat_t                  stat
);

    logic [sdtq_pkg::HANDLE_BITS-1:0] handle_reg;
    logic [TIME_BITS-1:0]             t_reg;
    logic [TIME_BITS-1:0]             now_reg;

    logic [TIME_BITS-1:0]             exp_reg [DEPTH];
    logic [sdtq_pkg::HANDLE_BITS-1:0] own_reg [DEPTH];
    logic [DEPTH-1:0]                 occ_reg;
    logic [DEPTH-1:0]                 occ_next;

    logic [DEPTH-1:0] le;
    logic [DEPTH-1:0] match;
    logic [DEPTH-1:0] sel;
    logic [DEPTH-1:0] after;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            handle_reg <= in_handle;
            t_reg      <= in_time;
            now_reg    <= in_now;
        end
    end

    assign handle_q = handle_reg;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [TIME_BITS-1:0]             prv_exp;
            logic [sdtq_pkg::HANDLE_BITS-1:0] prv_own;
            logic                             prv_occ;
            logic                             prv_le;
            logic                             prv_after;
            logic [TIME_BITS-1:0]             nxt_exp;
            logic [sdtq_pkg::HANDLE_BITS-1:0] nxt_own;
            logic                             nxt_occ;
            logic [TIME_BITS-1:0]             exp_next;
            logic [sdtq_pkg::HANDLE_BITS-1:0] own_next;

            if (i == 0)
            begin : g_first
                assign prv_exp   = t_reg;
                assign prv_own   = handle_reg;
                assign prv_occ   = 1'b1;
                assign prv_le    = 1'b1;
                assign prv_after = 1'b0;
            end
            else
            begin : g_mid
                assign prv_exp   = exp_reg[i-1];
                assign prv_own   = own_reg[i-1];
                assign prv_occ   = occ_reg[i-1];
                assign prv_le    = le[i-1];
                assign prv_after = after[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign nxt_exp = exp_reg[i];
                assign nxt_own = own_reg[i];
                assign nxt_occ = 1'b0;
            end
            else
            begin : g_inner
                assign nxt_exp = exp_reg[i+1];
                assign nxt_own = own_reg[i+1];
                assign nxt_occ = occ_reg[i+1];
            end

            assign le[i]    = occ_reg[i] && (exp_reg[i] <= t_reg);
            assign match[i] = occ_reg[i] && (own_reg[i] == handle_reg);
            assign sel[i]   = cmd.pop ? (i == 0) : match[i];
            assign after[i] = prv_after | sel[i];

            always_comb
            begin
                exp_next    = exp_reg[i];
                own_next    = own_reg[i];
                occ_next[i] = occ_reg[i];
                if (cmd.ins && !le[i])
                begin
                    // The new timer lands in the first cell that holds a later expiry or is empty.
                    if (prv_le)
                    begin
                        exp_next = t_reg;
                        own_next = handle_reg;
                    end
                    else
                    begin
                        exp_next = prv_exp;
                        own_next = prv_own;
                    end
                    occ_next[i] = occ_reg[i] | prv_occ;
                end
                else if ((cmd.del || cmd.pop) && after[i])
                begin
                    exp_next    = nxt_exp;
                    own_next    = nxt_own;
                    occ_next[i] = nxt_occ;
                end
            end

            always_ff @(posedge clk)
            begin
                exp_reg[i] <= exp_next;
                own_reg[i] <= own_next;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    assign stat.found      = |match;
    assign stat.full       = occ_reg[DEPTH-1];
    assign stat.head_exp   = occ_reg[0] && (exp_reg[0] <= now_reg);
    assign stat.next_exp   = occ_reg[1] && (exp_reg[1] <= now_reg);
    assign stat.head_owner = own_reg[0];

    a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg & ~{occ_reg[DEPTH-2:0], 1'b1}) == '0)
        else $error("occupied cells do not form a prefix");
    a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins |-> !stat.full)
        else $error("insert issued into a full row");
    a_del_found: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.del |-> stat.found)
        else $error("delete issued for a missing handle");
    a_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(match) <= 1)
        else $error("handle held by more than one cell");

endmodule

>>> rtl/core/sdtq_ctrl.sv
`timescale 1ns / 1ps
// Controller of the timer queue: sequences each operation and owns the output word register.
// Depends on sdtq_pkg.
module sdtq_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       in_func,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [sdtq_pkg::HANDLE_BITS-1:0] out_handle,
    output logic [sdtq_pkg::STATUS_BITS-1:0] out_status,
    output logic                             out_last,
    input  logic [sdtq_pkg::HANDLE_BITS-1:0] handle_q,
    input  sdtq_pkg::stat_t                  stat,
    output sdtq_pkg::cmd_t                   cmd
);

    sdtq_pkg::state_t state_reg, state_next;
    logic [1:0] func_reg;
    logic       ovalid_reg, ovalid_next;
    logic [sdtq_pkg::HANDLE_BITS-1:0] ohandle_reg, ohandle_next;
    logic [sdtq_pkg::STATUS_BITS-1:0] ostatus_reg, ostatus_next;
    logic olast_reg, olast_next;
    logic ofree;
    logic load_out;

    assign ofree = !ovalid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sdtq_pkg::S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= in_func;
        end
        ohandle_reg <= ohandle_next;
        ostatus_reg <= ostatus_next;
        olast_reg   <= olast_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        load_out     = 1'b0;
        ohandle_next = ohandle_reg;
        ostatus_next = ostatus_reg;
        olast_next   = olast_reg;
        case (state_reg)
            sdtq_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sdtq_pkg::S_EXEC;
                end
            end
            sdtq_pkg::S_EXEC:
            begin
                if (ofree)
                begin
                    load_out     = 1'b1;
                    ohandle_next = handle_q;
                    olast_next   = 1'b1;
                    state_next   = sdtq_pkg::S_IDLE;
                    case (func_reg)
                        sdtq_pkg::FUNC_INSERT:
                        begin
                            if (stat.found)
                                ostatus_next = sdtq_pkg::ST_PRESENT;
                            else if (stat.full)
                                ostatus_next = sdtq_pkg::ST_FULL;
                            else
                            begin
                                cmd.ins      = 1'b1;
                                ostatus_next = sdtq_pkg::ST_DONE;
                            end
                        end
                        sdtq_pkg::FUNC_DELETE, sdtq_pkg::FUNC_ADJUST:
                        begin
                            if (!stat.found)
                                ostatus_next = sdtq_pkg::ST_MISSING;
                            else if (func_reg == sdtq_pkg::FUNC_DELETE)
                            begin
                                cmd.del      = 1'b1;
                                ostatus_next = sdtq_pkg::ST_DONE;
                            end
                            else
                            begin
                                // Adjust takes the timer out now and places it again in S_REINS.
                                cmd.del    = 1'b1;
                                load_out   = 1'b0;
                                state_next = sdtq_pkg::S_REINS;
                            end
                        end
                        default:
                        begin
                            if (!stat.head_exp)
                            begin
                                ohandle_next = '0;
                                ostatus_next = sdtq_pkg::ST_NONE;
                            end
                            else
                            begin
                                cmd.pop      = 1'b1;
                                ohandle_next = stat.head_owner;
                                ostatus_next = sdtq_pkg::ST_EXPIRED;
                                olast_next   = !stat.next_exp;
                                if (stat.next_exp)
                                    state_next = sdtq_pkg::S_EXEC;
                            end
                        end
                    endcase
                end
            end
            sdtq_pkg::S_REINS:
            begin
                if (ofree)
                begin
                    cmd.ins      = 1'b1;
                    load_out     = 1'b1;
                    ohandle_next = handle_q;
                    ostatus_next = sdtq_pkg::ST_DONE;
                    olast_next   = 1'b1;
                    state_next   = sdtq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sdtq_pkg::S_IDLE;
            end
        endcase
        ovalid_next = load_out || (ovalid_reg && !out_ready);
    end

    assign out_valid  = ovalid_reg;
    assign out_handle = ohandle_reg;
    assign out_status = ostatus_reg;
    assign out_last   = olast_reg;

endmodule
